FILE: design/rat_pkg.sv
package rat_pkg;

	localparam int TABLE_ENTRIES_DEF = 16;
	localparam int UID_BYTES_DEF     = 10;

	localparam logic [7:0] REPEAT_HOLD_RST = 8'd3;
	localparam logic [7:0] DOOR_OPEN_RST   = 8'd3;
	localparam logic [7:0] DENIED_SHOW_RST = 8'd5;

	typedef enum logic [1:0] {
		CMD_ADD     = 2'd0,
		CMD_REMOVE  = 2'd1,
		CMD_PRESENT = 2'd2,
		CMD_TICK    = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_ADDED     = 4'd0,
		ST_DUPLICATE = 4'd1,
		ST_TOO_LONG  = 4'd2,
		ST_FULL      = 4'd3,
		ST_REMOVED   = 4'd4,
		ST_NOT_FOUND = 4'd5,
		ST_EMPTY     = 4'd6,
		ST_GRANTED   = 4'd7,
		ST_DENIED    = 4'd8,
		ST_REPEAT    = 4'd9,
		ST_TICKED    = 4'd10
	} status_t;

	typedef enum logic [1:0] {
		CFG_REPEAT_HOLD = 2'd0,
		CFG_DOOR_OPEN   = 2'd1,
		CFG_DENIED_SHOW = 2'd2
	} cfg_idx_t;

	localparam logic [1:0] DISP_BLANK  = 2'd0;
	localparam logic [1:0] DISP_HOLDER = 2'd1;
	localparam logic [1:0] DISP_DENIED = 2'd2;

	typedef enum logic [1:0] {
		RES_ZERO  = 2'd0,
		RES_RDATA = 2'd1,
		RES_CAPT  = 2'd2,
		RES_NEXT  = 2'd3
	} res_src_t;

	typedef struct packed {
		logic [63:0] uid_lo;
		logic [15:0] uid_hi;
		logic [3:0]  len;
		logic [7:0]  holder;
		logic [15:0] number;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// controller to datapath
	typedef struct packed {
		logic     load;
		logic     idx_clr;
		logic     idx_inc;
		logic     wr_new;
		logic     wr_shift;
		logic     cnt_dec;
		logic     cap_num;
		logic     present_upd;
		logic     grant;
		logic     deny;
		logic     tick;
		logic     finish;
		status_t  status;
		res_src_t res_src;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		cmd_t item_cmd;
		logic too_long;
		logic saved_hit;
		logic hit;
		logic idx_last;
		logic empty;
		logic full;
	} dp_stat_t;

	function automatic logic [63:0] mask_low(input logic [3:0] n);
		logic [63:0] m;
		m = '0;
		for (int b = 0; b < 8; b++) begin
			if (4'(b) < n) m[b*8 +: 8] = 8'hff;
		end
		return m;
	endfunction

	function automatic logic [15:0] mask_high(input logic [3:0] n);
		logic [15:0] m;
		m = '0;
		if (n > 4'd8) m[7:0] = 8'hff;
		if (n > 4'd9) m[15:8] = 8'hff;
		return m;
	endfunction

	function automatic logic same_bytes(input logic [63:0] alo, input logic [15:0] ahi,
			input logic [63:0] blo, input logic [15:0] bhi, input logic [3:0] n);
		return (((alo ^ blo) & mask_low(n)) == 64'd0) && (((ahi ^ bhi) & mask_high(n)) == 16'd0);
	endfunction

endpackage

FILE: design/rat_ram.sv
module rat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		rd_data <= mem_q[rd_addr];
	end

endmodule

FILE: design/rat_datapath.sv
module rat_datapath #(
	parameter int TABLE_ENTRIES = rat_pkg::TABLE_ENTRIES_DEF,
	parameter int UID_BYTES     = rat_pkg::UID_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rat_pkg::ctl_cmd_t ctl,
	output rat_pkg::dp_stat_t stat,
	input  logic [1:0]        cmd,
	input  logic [63:0]       uid_low,
	input  logic [15:0]       uid_high,
	input  logic [3:0]        uid_len,
	input  logic [7:0]        holder,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [7:0]        cfg_data,
	output logic              done,
	output logic [3:0]        status,
	output logic [15:0]       entry_number,
	output logic [7:0]        holder_out,
	output logic              door_unlocked,
	output logic [1:0]        display_mode
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam logic [3:0] LEN_MAX = 4'(UID_BYTES);

	rat_pkg::cmd_t   item_cmd_q;
	logic [63:0]     lo_q;
	logic [15:0]     hi_q;
	logic [3:0]      len_q;
	logic            long_q;
	logic [7:0]      holder_q;

	logic [7:0]      repeat_hold_q, door_ticks_q, denied_ticks_q;
	logic [7:0]      repeat_timer_q, door_timer_q, disp_timer_q;
	logic [1:0]      disp_state_q;
	logic [63:0]     saved_lo_q;
	logic [15:0]     saved_hi_q;
	logic            saved_act_q;
	logic [15:0]     next_num_q, capt_num_q;

	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W:0]   idx_nxt;

	logic [3:0]       len_cap;
	rat_pkg::entry_t  rd_ent, wr_ent;
	logic [IDX_W-1:0] wr_addr;
	logic [3:0]       hit_len;
	logic [rat_pkg::ENTRY_W-1:0] rd_raw;

	assign len_cap = (uid_len > LEN_MAX) ? LEN_MAX : uid_len;

	rat_ram #(.WIDTH(rat_pkg::ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_ram (
		.clk     (clk),
		.wr_en   (ctl.wr_new | ctl.wr_shift),
		.wr_addr (wr_addr),
		.wr_data (wr_ent),
		.rd_addr (idx_q),
		.rd_data (rd_raw)
	);

	assign rd_ent  = rat_pkg::entry_t'(rd_raw);
	assign wr_addr = ctl.wr_new ? cnt_q[IDX_W-1:0] : idx_q - IDX_W'(1);

	always_comb begin
		if (ctl.wr_new) begin
			wr_ent.uid_lo = lo_q;
			wr_ent.uid_hi = hi_q;
			wr_ent.len    = len_q;
			wr_ent.holder = holder_q;
			wr_ent.number = next_num_q;
		end else begin
			wr_ent = rd_ent;
		end
	end

	// add and remove compare under the stored length, a card under its own
	assign hit_len = (item_cmd_q == rat_pkg::CMD_PRESENT) ? len_q : rd_ent.len;
	assign idx_nxt = (CNT_W+1)'(idx_q) + (CNT_W+1)'(1);

	assign stat.item_cmd  = item_cmd_q;
	assign stat.too_long  = long_q;
	assign stat.saved_hit = saved_act_q &&
		rat_pkg::same_bytes(saved_lo_q, saved_hi_q, lo_q, hi_q, len_q);
	assign stat.hit       = rat_pkg::same_bytes(rd_ent.uid_lo, rd_ent.uid_hi, lo_q, hi_q, hit_len);
	assign stat.idx_last  = idx_nxt >= {1'b0, cnt_q};
	assign stat.empty     = cnt_q == '0;
	assign stat.full      = cnt_q == CNT_W'(TABLE_ENTRIES);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			item_cmd_q <= rat_pkg::cmd_t'(cmd);
			lo_q       <= uid_low & rat_pkg::mask_low(len_cap);
			hi_q       <= uid_high & rat_pkg::mask_high(len_cap);
			len_q      <= len_cap;
			long_q     <= uid_len > LEN_MAX;
			holder_q   <= holder;
		end
		if (ctl.cap_num) capt_num_q <= rd_ent.number;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repeat_hold_q  <= rat_pkg::REPEAT_HOLD_RST;
			door_ticks_q   <= rat_pkg::DOOR_OPEN_RST;
			denied_ticks_q <= rat_pkg::DENIED_SHOW_RST;
			repeat_timer_q <= '0;
			door_timer_q   <= '0;
			disp_timer_q   <= '0;
			disp_state_q   <= rat_pkg::DISP_BLANK;
			saved_lo_q     <= '0;
			saved_hi_q     <= '0;
			saved_act_q    <= 1'b0;
			next_num_q     <= '0;
			cnt_q          <= '0;
			idx_q          <= '0;
			done           <= 1'b0;
			status         <= '0;
			entry_number   <= '0;
			holder_out     <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					rat_pkg::CFG_REPEAT_HOLD: repeat_hold_q  <= cfg_data;
					rat_pkg::CFG_DOOR_OPEN:   door_ticks_q   <= cfg_data;
					rat_pkg::CFG_DENIED_SHOW: denied_ticks_q <= cfg_data;
					default: ;
				endcase
			end

			if (ctl.idx_clr) idx_q <= '0;
			else if (ctl.idx_inc) idx_q <= idx_q + IDX_W'(1);

			if (ctl.wr_new) begin
				cnt_q      <= cnt_q + CNT_W'(1);
				next_num_q <= next_num_q + 16'd1;
			end else if (ctl.cnt_dec) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end

			if (ctl.present_upd) begin
				repeat_timer_q <= repeat_hold_q;
				saved_act_q    <= repeat_hold_q != 8'd0;
				saved_lo_q     <= (repeat_hold_q != 8'd0) ? lo_q : 64'd0;
				saved_hi_q     <= (repeat_hold_q != 8'd0) ? hi_q : 16'd0;
			end

			if (ctl.grant) begin
				door_timer_q <= door_ticks_q;
				disp_timer_q <= door_ticks_q;
				disp_state_q <= (door_ticks_q != 8'd0) ? rat_pkg::DISP_HOLDER : rat_pkg::DISP_BLANK;
			end else if (ctl.deny) begin
				door_timer_q <= '0;
				disp_timer_q <= denied_ticks_q;
				disp_state_q <= (denied_ticks_q != 8'd0) ? rat_pkg::DISP_DENIED : rat_pkg::DISP_BLANK;
			end else if (ctl.tick) begin
				if (repeat_timer_q != 8'd0) begin
					repeat_timer_q <= repeat_timer_q - 8'd1;
					if (repeat_timer_q == 8'd1) begin
						saved_act_q <= 1'b0;
						saved_lo_q  <= '0;
						saved_hi_q  <= '0;
					end
				end
				if (door_timer_q != 8'd0) door_timer_q <= door_timer_q - 8'd1;
				if (disp_timer_q != 8'd0) begin
					disp_timer_q <= disp_timer_q - 8'd1;
					if (disp_timer_q == 8'd1) disp_state_q <= rat_pkg::DISP_BLANK;
				end
			end

			done <= ctl.finish;
			if (ctl.finish) begin
				status     <= ctl.status;
				holder_out <= ctl.grant ? rd_ent.holder : 8'd0;
				case (ctl.res_src)
					rat_pkg::RES_RDATA: entry_number <= rd_ent.number;
					rat_pkg::RES_CAPT:  entry_number <= capt_num_q;
					rat_pkg::RES_NEXT:  entry_number <= next_num_q;
					default:            entry_number <= 16'd0;
				endcase
			end
		end
	end

	assign door_unlocked = door_timer_q != 8'd0;
	assign display_mode  = disp_state_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(TABLE_ENTRIES)) else $error("entry count beyond table size");
	a_no_add_full: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.wr_new |-> !stat.full) else $error("add into full table");
	a_shift_idx: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.wr_shift |-> (idx_q != '0 && !ctl.wr_new)) else $error("bad shift write");
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.finish |=> done) else $error("finished request gave no strobe");

endmodule

FILE: design/rat_ctrl.sv
module rat_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  rat_pkg::dp_stat_t stat,
	output rat_pkg::ctl_cmd_t ctl
);

	typedef enum logic [2:0] {
		S_IDLE, S_DISPATCH, S_RD, S_CMP, S_END, S_SH_RD, S_SH_WR
	} state_t;

	state_t state_q, state_d;

	assign busy = state_q != S_IDLE;

	always_comb begin
		ctl     = '0;
		ctl.status  = rat_pkg::ST_TICKED;
		ctl.res_src = rat_pkg::RES_ZERO;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				ctl.idx_clr = 1'b1;
				unique case (stat.item_cmd)
					rat_pkg::CMD_TICK: begin
						ctl.tick   = 1'b1;
						ctl.finish = 1'b1;
						state_d    = S_IDLE;
					end
					rat_pkg::CMD_ADD: begin
						if (stat.too_long) begin
							ctl.finish = 1'b1;
							ctl.status = rat_pkg::ST_TOO_LONG;
							state_d    = S_IDLE;
						end else begin
							state_d = stat.empty ? S_END : S_RD;
						end
					end
					rat_pkg::CMD_REMOVE: begin
						if (stat.empty) begin
							ctl.finish = 1'b1;
							ctl.status = rat_pkg::ST_EMPTY;
							state_d    = S_IDLE;
						end else begin
							state_d = S_RD;
						end
					end
					default: begin
						if (stat.saved_hit) begin
							ctl.finish = 1'b1;
							ctl.status = rat_pkg::ST_REPEAT;
							state_d    = S_IDLE;
						end else begin
							ctl.present_upd = 1'b1;
							state_d = stat.empty ? S_END : S_RD;
						end
					end
				endcase
			end
			S_RD: state_d = S_CMP;
			S_CMP: begin
				if (stat.hit) begin
					unique case (stat.item_cmd)
						rat_pkg::CMD_ADD: begin
							ctl.finish  = 1'b1;
							ctl.status  = rat_pkg::ST_DUPLICATE;
							ctl.res_src = rat_pkg::RES_RDATA;
							state_d     = S_IDLE;
						end
						rat_pkg::CMD_REMOVE: begin
							ctl.cap_num = 1'b1;
							if (stat.idx_last) begin
								ctl.cnt_dec = 1'b1;
								ctl.finish  = 1'b1;
								ctl.status  = rat_pkg::ST_REMOVED;
								ctl.res_src = rat_pkg::RES_RDATA;
								state_d     = S_IDLE;
							end else begin
								ctl.idx_inc = 1'b1;
								state_d     = S_SH_RD;
							end
						end
						default: begin
							ctl.grant   = 1'b1;
							ctl.finish  = 1'b1;
							ctl.status  = rat_pkg::ST_GRANTED;
							ctl.res_src = rat_pkg::RES_RDATA;
							state_d     = S_IDLE;
						end
					endcase
				end else if (stat.idx_last) begin
					state_d = S_END;
				end else begin
					ctl.idx_inc = 1'b1;
					state_d     = S_RD;
				end
			end
			S_END: begin
				ctl.finish = 1'b1;
				state_d    = S_IDLE;
				unique case (stat.item_cmd)
					rat_pkg::CMD_ADD: begin
						if (stat.full) begin
							ctl.status = rat_pkg::ST_FULL;
						end else begin
							ctl.wr_new  = 1'b1;
							ctl.status  = rat_pkg::ST_ADDED;
							ctl.res_src = rat_pkg::RES_NEXT;
						end
					end
					rat_pkg::CMD_REMOVE: ctl.status = rat_pkg::ST_NOT_FOUND;
					default: begin
						ctl.deny   = 1'b1;
						ctl.status = rat_pkg::ST_DENIED;
					end
				endcase
			end
			S_SH_RD: state_d = S_SH_WR;
			S_SH_WR: begin
				ctl.wr_shift = 1'b1;
				if (stat.idx_last) begin
					ctl.cnt_dec = 1'b1;
					ctl.finish  = 1'b1;
					ctl.status  = rat_pkg::ST_REMOVED;
					ctl.res_src = rat_pkg::RES_CAPT;
					state_d     = S_IDLE;
				end else begin
					ctl.idx_inc = 1'b1;
					state_d     = S_SH_RD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> state_q == S_DISPATCH) else $error("request not taken");
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.wr_new, ctl.wr_shift, ctl.load})) else $error("conflicting commands");
	a_timer_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.grant, ctl.deny, ctl.tick})) else $error("conflicting timer commands");

endmodule

FILE: design/rfid_access_table.sv
// channel   direction  handshake             payload
// request   in         start & !busy         cmd, uid_low, uid_high, uid_len, holder
// result    out        done, one cycle       status, entry_number, holder_out,
//                                            door_unlocked, display_mode
// config    in         cfg_valid & cfg_ready cfg_index, cfg_data
//
// tick, repeat, too long and empty requests finish in the dispatch state; done is registered from it
// a lookup reads the table one entry at a time, each in a read state and then a compare state
// a remove then shifts each later entry down one place, in a shift-read and a shift-write state
// the read of the entry ram is registered; reset clears the fill count, timers and settings, not the ram
// the receiver cannot stall: done is high for one cycle, start may follow at once
module rfid_access_table #(
	parameter int TABLE_ENTRIES = rat_pkg::TABLE_ENTRIES_DEF,
	parameter int UID_BYTES     = rat_pkg::UID_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [63:0] uid_low,
	input  logic [15:0] uid_high,
	input  logic [3:0]  uid_len,
	input  logic [7:0]  holder,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	output logic        done,
	output logic [3:0]  status,
	output logic [15:0] entry_number,
	output logic [7:0]  holder_out,
	output logic        door_unlocked,
	output logic [1:0]  display_mode
);

	rat_pkg::ctl_cmd_t ctl;   // sequencer commands
	rat_pkg::dp_stat_t stat;  // compare and count flags

	// registers are always writable
	assign cfg_ready = 1'b1;

	rat_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.ctl    (ctl)
	);

	rat_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES), .UID_BYTES(UID_BYTES)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.stat          (stat),
		.cmd           (cmd),
		.uid_low       (uid_low),
		.uid_high      (uid_high),
		.uid_len       (uid_len),
		.holder        (holder),
		.cfg_we        (cfg_valid & cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.done          (done),
		.status        (status),
		.entry_number  (entry_number),
		.holder_out    (holder_out),
		.door_unlocked (door_unlocked),
		.display_mode  (display_mode)
	);

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;

	localparam int SLOTS    = rat_pkg::TABLE_ENTRIES_DEF;
	localparam int MAX_UID  = rat_pkg::UID_BYTES_DEF;
	localparam int STALL_LIMIT = 4000;
	localparam int POOL_SIZE   = 20;

	// one request as the driver presents it
	typedef struct packed {
		rat_pkg::cmd_t op;
		logic [63:0]   lo;
		logic [15:0]   hi;
		logic [3:0]    len;
		logic [7:0]    hold;
	} card_req_t;

	// one result as the block reports it
	typedef struct packed {
		rat_pkg::status_t st;
		logic [15:0]      num;
		logic [7:0]       hold;
		logic             door;
		logic [1:0]       disp;
	} door_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  cmd = '0;
	logic [63:0] uid_low = '0;
	logic [15:0] uid_high = '0;
	logic [3:0]  uid_len = '0;
	logic [7:0]  holder = '0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;
	logic        done;
	logic [3:0]  status;
	logic [15:0] entry_number;
	logic [7:0]  holder_out;
	logic        door_unlocked;
	logic [1:0]  display_mode;

	rfid_access_table dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .uid_low(uid_low), .uid_high(uid_high), .uid_len(uid_len),
		.holder(holder), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .done(done), .status(status),
		.entry_number(entry_number), .holder_out(holder_out),
		.door_unlocked(door_unlocked), .display_mode(display_mode)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// queues between stimulus, driver and checker
	card_req_t    pending_reqs[$];
	door_result_t awaited_results[$];
	int           fail_count = 0;
	int           idle_pct = 30;
	bit           req_taken = 1'b0;
	bit           cfg_taken = 1'b0;
	int           quiet_cycles = 0;

	// shadow copy of the whitelist and timers
	logic [79:0] sh_uid[SLOTS];
	logic [3:0]  sh_len[SLOTS];
	logic [7:0]  sh_holder[SLOTS];
	logic [15:0] sh_num[SLOTS];
	int          sh_fill = 0;
	logic [15:0] sh_next = '0;
	logic [79:0] sh_saved = '0;
	bit          sh_saved_on = 1'b0;
	logic [7:0]  sh_rep_t = '0, sh_door_t = '0, sh_disp_t = '0;
	logic [1:0]  sh_disp = rat_pkg::DISP_BLANK;
	logic [7:0]  hold_ticks = rat_pkg::REPEAT_HOLD_RST;
	logic [7:0]  open_ticks = rat_pkg::DOOR_OPEN_RST;
	logic [7:0]  deny_ticks = rat_pkg::DENIED_SHOW_RST;

	// byte mask over the 80-bit uid, first n bytes kept
	function automatic logic [79:0] byte_keep(input int n);
		logic [79:0] k;
		k = '0;
		for (int b = 0; b < MAX_UID; b++)
			if (b < n) k[8*b +: 8] = 8'hff;
		return k;
	endfunction

	// first stored entry matching key over its own stored length
	function automatic int oldest_stored_match(input logic [79:0] key);
		for (int i = 0; i < sh_fill; i++)
			if (((sh_uid[i] ^ key) & byte_keep(sh_len[i])) == '0) return i;
		return -1;
	endfunction

	task automatic access_decision(input card_req_t rq, output door_result_t r);
		int          n;
		int          m;
		logic [79:0] key;
		n = (rq.len > MAX_UID) ? MAX_UID : rq.len;
		key = {rq.hi, rq.lo} & byte_keep(n);
		m = -1;
		r = '0;
		case (rq.op)
			rat_pkg::CMD_ADD: begin
				m = oldest_stored_match(key);
				if (rq.len > MAX_UID) r.st = rat_pkg::ST_TOO_LONG;
				else if (m >= 0) begin
					r.st = rat_pkg::ST_DUPLICATE;
					r.num = sh_num[m];
				end else if (sh_fill >= SLOTS) r.st = rat_pkg::ST_FULL;
				else begin
					sh_uid[sh_fill] = key;
					sh_len[sh_fill] = 4'(n);
					sh_holder[sh_fill] = rq.hold;
					sh_num[sh_fill] = sh_next;
					sh_fill++;
					r.st = rat_pkg::ST_ADDED;
					r.num = sh_next;
					sh_next = sh_next + 16'd1;
				end
			end
			rat_pkg::CMD_REMOVE: begin
				if (sh_fill == 0) r.st = rat_pkg::ST_EMPTY;
				else begin
					m = oldest_stored_match(key);
					if (m < 0) r.st = rat_pkg::ST_NOT_FOUND;
					else begin
						// later entries slide down one slot
						r.st = rat_pkg::ST_REMOVED;
						r.num = sh_num[m];
						for (int i = m; i + 1 < sh_fill; i++) begin
							sh_uid[i] = sh_uid[i+1];
							sh_len[i] = sh_len[i+1];
							sh_holder[i] = sh_holder[i+1];
							sh_num[i] = sh_num[i+1];
						end
						sh_fill--;
					end
				end
			end
			rat_pkg::CMD_PRESENT: begin
				if (sh_saved_on && (((sh_saved ^ key) & byte_keep(n)) == '0))
					r.st = rat_pkg::ST_REPEAT;
				else begin
					sh_saved = key;
					sh_rep_t = hold_ticks;
					sh_saved_on = (sh_rep_t != 0);
					if (!sh_saved_on) sh_saved = '0;
					// lookup compares over the presented length
					for (int i = 0; i < sh_fill && m < 0; i++)
						if (((sh_uid[i] ^ key) & byte_keep(n)) == '0) m = i;
					if (m >= 0) begin
						r.st = rat_pkg::ST_GRANTED;
						r.num = sh_num[m];
						r.hold = sh_holder[m];
						sh_door_t = open_ticks;
						sh_disp_t = open_ticks;
						sh_disp = (sh_disp_t != 0) ? rat_pkg::DISP_HOLDER : rat_pkg::DISP_BLANK;
					end else begin
						r.st = rat_pkg::ST_DENIED;
						sh_door_t = '0;
						sh_disp_t = deny_ticks;
						sh_disp = (sh_disp_t != 0) ? rat_pkg::DISP_DENIED : rat_pkg::DISP_BLANK;
					end
				end
			end
			default: begin
				r.st = rat_pkg::ST_TICKED;
				if (sh_rep_t != 0) begin
					sh_rep_t--;
					if (sh_rep_t == 0) begin
						sh_saved_on = 1'b0;
						sh_saved = '0;
					end
				end
				if (sh_door_t != 0) sh_door_t--;
				if (sh_disp_t != 0) begin
					sh_disp_t--;
					if (sh_disp_t == 0) sh_disp = rat_pkg::DISP_BLANK;
				end
			end
		endcase
		r.door = (sh_door_t != 0);
		r.disp = sh_disp;
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	// driver: one request at a time, random gaps
	card_req_t cur_req;
	always @(negedge clk) begin
		if (arst_n && (!start || req_taken)) begin
			if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
				cur_req = pending_reqs.pop_front();
				cmd      <= cur_req.op;
				uid_low  <= cur_req.lo;
				uid_high <= cur_req.hi;
				uid_len  <= cur_req.len;
				holder   <= cur_req.hold;
				start    <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: record accepted requests, check each result against the oldest prediction
	always @(posedge clk) begin
		card_req_t    seen;
		door_result_t want;
		req_taken = arst_n && start && !busy;
		cfg_taken = arst_n && cfg_valid && cfg_ready;
		if (req_taken) begin
			seen = '{op: rat_pkg::cmd_t'(cmd), lo: uid_low, hi: uid_high, len: uid_len,
				hold: holder};
			access_decision(seen, want);
			awaited_results.push_back(want);
		end
		if (cfg_taken) begin
			case (rat_pkg::cfg_idx_t'(cfg_index))
				rat_pkg::CFG_REPEAT_HOLD: hold_ticks = cfg_data;
				rat_pkg::CFG_DOOR_OPEN:   open_ticks = cfg_data;
				rat_pkg::CFG_DENIED_SHOW: deny_ticks = cfg_data;
				default: ;
			endcase
		end
		if (arst_n && done) begin
			if (awaited_results.size() == 0) begin
				report_mismatch("unexpected result", 64'(status), 64'd0);
			end else begin
				want = awaited_results.pop_front();
				if (status != want.st) report_mismatch("status", 64'(status), 64'(want.st));
				if (entry_number != want.num)
					report_mismatch("entry_number", 64'(entry_number), 64'(want.num));
				if (holder_out != want.hold)
					report_mismatch("holder_out", 64'(holder_out), 64'(want.hold));
				if (door_unlocked != want.door)
					report_mismatch("door_unlocked", 64'(door_unlocked), 64'(want.door));
				if (display_mode != want.disp)
					report_mismatch("display_mode", 64'(display_mode), 64'(want.disp));
			end
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if (req_taken || cfg_taken || done || !arst_n) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("rfid_access_table verification failed");
			$finish;
		end
	end

	// uid pool so adds, removes and presentations hit each other
	logic [63:0] pool_lo[POOL_SIZE];
	logic [15:0] pool_hi[POOL_SIZE];
	logic [3:0]  pool_len[POOL_SIZE];

	function automatic card_req_t make_req(input rat_pkg::cmd_t op, input logic [63:0] lo,
			input logic [15:0] hi, input logic [3:0] len, input logic [7:0] hold);
		make_req = '{op: op, lo: lo, hi: hi, len: len, hold: hold};
	endfunction

	// random request; add_weight shifts the mix toward filling the table
	function automatic card_req_t random_req(input int add_weight);
		card_req_t rq;
		int        pick;
		int        p;
		pick = $urandom_range(99);
		if (pick < add_weight) rq.op = rat_pkg::CMD_ADD;
		else if (pick < add_weight + 20) rq.op = rat_pkg::CMD_REMOVE;
		else if (pick < add_weight + 50) rq.op = rat_pkg::CMD_PRESENT;
		else rq.op = rat_pkg::CMD_TICK;
		rq.hold = 8'($urandom);
		if ($urandom_range(99) < 80) begin
			p = $urandom_range(POOL_SIZE - 1);
			rq.lo = pool_lo[p];
			rq.hi = pool_hi[p];
			rq.len = pool_len[p];
			// sometimes present a shorter prefix or a capped long length
			if ($urandom_range(9) == 0) rq.len = 4'($urandom_range(15));
		end else begin
			rq.lo = {$urandom, $urandom};
			rq.hi = 16'($urandom);
			rq.len = ($urandom_range(9) == 0) ? 4'($urandom_range(11, 15))
			                                  : 4'($urandom_range(1, 10));
		end
		return rq;
	endfunction

	task automatic write_reg(input rat_pkg::cfg_idx_t idx, input logic [7:0] val);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		do @(negedge clk); while (!cfg_taken);
		cfg_valid <= 1'b0;
	endtask

	// block goes idle once every prediction is matched; then allow the tail latency
	task automatic drain;
		while (pending_reqs.size() > 0 || awaited_results.size() > 0 || start)
			@(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	initial begin
		logic [63:0] full_lo;
		logic [7:0]  reg_vals[3];
		full_lo = '1;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty table, length limits, duplicate, repeat window,
		// denied, capped length, zero-length entry matching every add and remove
		pending_reqs.push_back(make_req(rat_pkg::CMD_REMOVE, 64'h1234, 16'h0, 4'd2, 8'd0));
		pending_reqs.push_back(make_req(rat_pkg::CMD_ADD, full_lo, 16'hffff, 4'd10, 8'hff));
		pending_reqs.push_back(make_req(rat_pkg::CMD_ADD, 64'h55, 16'h0, 4'd11, 8'd1));
		pending_reqs.push_back(make_req(rat_pkg::CMD_ADD, full_lo, 16'hffff, 4'd15, 8'd2));
		pending_reqs.push_back(make_req(rat_pkg::CMD_ADD, full_lo, 16'hffff, 4'd10, 8'd3));
		pending_reqs.push_back(make_req(rat_pkg::CMD_ADD, 64'hdeadbeef, 16'h0, 4'd4, 8'h00));
		pending_reqs.push_back(make_req(rat_pkg::CMD_PRESENT, full_lo, 16'hffff, 4'd10, 8'd0));
		pending_reqs.push_back(make_req(rat_pkg::CMD_PRESENT, full_lo, 16'hffff, 4'd10, 8'd0));
		repeat (3) pending_reqs.push_back(make_req(rat_pkg::CMD_TICK, '0, '0, 4'd0, 8'd0));
		pending_reqs.push_back(make_req(rat_pkg::CMD_PRESENT, 64'h0bad, 16'h0, 4'd2, 8'd0));
		pending_reqs.push_back(make_req(rat_pkg::CMD_PRESENT, full_lo, 16'hffff, 4'd15, 8'd0));
		pending_reqs.push_back(make_req(rat_pkg::CMD_REMOVE, 64'h777, 16'h0, 4'd3, 8'd0));
		pending_reqs.push_back(make_req(rat_pkg::CMD_REMOVE, full_lo, 16'hffff, 4'd10, 8'd0));
		pending_reqs.push_back(make_req(rat_pkg::CMD_ADD, 64'h0, 16'h0, 4'd0, 8'd7));
		pending_reqs.push_back(make_req(rat_pkg::CMD_PRESENT, 64'h99, 16'h0, 4'd0, 8'd0));
		pending_reqs.push_back(make_req(rat_pkg::CMD_ADD, 64'hcafe, 16'h0, 4'd2, 8'd9));
		pending_reqs.push_back(make_req(rat_pkg::CMD_REMOVE, 64'hcafe, 16'h0, 4'd2, 8'd0));
		pending_reqs.push_back(make_req(rat_pkg::CMD_REMOVE, 64'hdeadbeef, 16'h0, 4'd4, 8'd0));
		repeat (6) pending_reqs.push_back(make_req(rat_pkg::CMD_TICK, '0, '0, 4'd0, 8'd0));
		drain();

		// random phases, each with its own register setting
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: reg_vals = '{8'd1, 8'd1, 8'd1};
				1: reg_vals = '{8'd255, 8'd255, 8'd255};
				default: reg_vals = '{8'($urandom_range(1, 8)), 8'($urandom_range(1, 8)),
				                      8'($urandom_range(1, 255))};
			endcase
			write_reg(rat_pkg::CFG_REPEAT_HOLD, reg_vals[0]);
			write_reg(rat_pkg::CFG_DOOR_OPEN, reg_vals[1]);
			write_reg(rat_pkg::CFG_DENIED_SHOW, reg_vals[2]);
			// a zero-length uid only rarely, it swallows every add and remove while stored
			for (int p = 0; p < POOL_SIZE; p++) begin
				pool_lo[p] = {$urandom, $urandom};
				pool_hi[p] = 16'($urandom);
				pool_len[p] = ($urandom_range(49) == 0) ? 4'd0 : 4'($urandom_range(1, 10));
			end
			idle_pct = (ph == 2) ? 0 : 30;
			for (int k = 0; k < 225; k++)
				pending_reqs.push_back(random_req((ph == 3) ? 55 : 30));
			drain();
		end

		if (fail_count == 0) begin
			$display("rfid_access_table verification clean");
		end else begin
			$display("rfid_access_table verification failed");
		end
		$finish;
	end

endmodule
